// ----- rtl/core/arith_encoder_32bit_renorm_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the arithmetic encoder core
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ARITH_ENCODER_32BIT_RENORM_CORE_MACROS_SVH
`define ARITH_ENCODER_32BIT_RENORM_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AER_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/aer_pkg.sv -----
// ----------------------------------------------------------------------------
// aer_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package aer_pkg;

  localparam int unsigned FREQ_BITS_DEF     = 16;
  localparam int unsigned PENDING_WIDTH_DEF = 32;

  localparam int unsigned CUM_LOW_W  = 16;
  localparam int unsigned CUM_HIGH_W = 17;
  localparam int unsigned RANGE_W    = 32;
  localparam int unsigned RUN_W      = 32;
  localparam int unsigned PAD_W      = 3;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  // Item kinds carried on s_tuser
  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_FINISH = 1'b1
  } aer_kind_t;

  // Commands from the controller, at most one per cycle
  typedef struct packed {
    logic load;
    logic mul_hi;
    logic mul_lo;
    logic update;
    logic step;
    logic flush;
    logic finish;
  } aer_cmd_t;

  // Status back from the datapath
  typedef struct packed {
    logic enc_ok;
    logic emit;
    logic e3;
    logic hold_valid;
    logic out_free;
  } aer_sts_t;

endpackage

// ----- rtl/core/arith_encoder_32bit_renorm_core.sv -----
// ----------------------------------------------------------------------------
// arith_encoder_32bit_renorm_core
// Binary arithmetic encoder, 32-bit interval, pending-bit renormalisation.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transfer per item. s_tuser selects the kind:
//   0 encode the symbol bounded by [cum_low, cum_high), 1 finish the stream.
// Output stream (m_*): one transfer per decided bit, carrying the bit, the
//   run of inverted bits that follows it and a saturation flag; m_tlast marks
//   the final result of an item. The finish result also carries the zero
//   padding needed to reach a byte boundary.
// Sequence: an encode item is accepted, uses the shared multiplier twice
//   (high bound, then low bound), updates the interval and runs the
//   renormalisation shifts (at most 18, underflow shifts included), then
//   closes the loop. The shift loop sets the rate. A finish item is accepted
//   and then builds its result once the output register is free. An encode
//   item with an empty interval is dropped in its acceptance cycle.
// Stalls: results go through a one-deep hold stage into the output register;
//   once both hold a result and m_tready is low, the shift loop waits at the
//   next decided bit, and no new item is accepted until the current one is done.
// Reset: rst (synchronous) returns the interval to [0, 0xFFFFFFFF], clears
//   the pending count, bit phase and flags and empties the output.
// ----------------------------------------------------------------------------
`include "arith_encoder_32bit_renorm_core_macros.svh"

module arith_encoder_32bit_renorm_core #(
  parameter int unsigned FREQ_BITS     = aer_pkg::FREQ_BITS_DEF,
  parameter int unsigned PENDING_WIDTH = aer_pkg::PENDING_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [aer_pkg::S_TDATA_W-1:0] s_tdata,  // cum_low[15:0], cum_high[32:16]
  input  logic                          s_tuser,  // kind[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [aer_pkg::M_TDATA_W-1:0] m_tdata,  // bit_value[0], inverted_run[32:1],
                                                  // run_saturated[33], pad_zeros[36:34]
  output logic                          m_tlast   // last
);
  import aer_pkg::*;

  aer_cmd_t cmd;
  aer_sts_t sts;

  // Sequencer: holds the item state and issues at most one command per cycle
  aer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Interval arithmetic, pending bits and the output register
  aer_datapath #(
    .FREQ_BITS     (FREQ_BITS),
    .PENDING_WIDTH (PENDING_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A new decided bit never overwrites a held one that cannot leave
  `AER_ASSERT_SAME(a_no_overwrite, cmd.step && sts.emit && sts.hold_valid, sts.out_free, "held result overwritten")

  // Closing an item always presents a result marked last
  `AER_ASSERT_NEXT(a_close_last, cmd.flush || cmd.finish, m_tvalid && m_tlast, "closing result not marked last")

  // The sequencer issues at most one command per cycle
  `AER_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.mul_hi, cmd.mul_lo, cmd.update, cmd.step, cmd.flush, cmd.finish}), "more than one command")

  // A finish transfer keeps the input closed while its result is built
  `AER_ASSERT_NEXT(a_finish_busy, s_tvalid && s_tready && s_tuser, !s_tready, "input open after finish transfer")

endmodule

// ----- rtl/core/aer_ctrl.sv -----
// ----------------------------------------------------------------------------
// aer_ctrl
// Sequencer: accept, two multiplies, interval update, one shift per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module aer_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  input  aer_pkg::aer_sts_t sts,
  output aer_pkg::aer_cmd_t cmd
);
  import aer_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_HI = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_RENORM = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == KIND_FINISH) begin
            state_next = ST_FINISH;
          end else if (sts.enc_ok) begin
            cmd.load   = 1'b1;
            state_next = ST_MUL_HI;
          end
        end
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_RENORM;
      end
      ST_RENORM: begin
        if (sts.emit) begin
          // a held result must leave before a new one takes its place
          if (!sts.hold_valid || sts.out_free) begin
            cmd.step = 1'b1;
          end
        end else if (sts.e3) begin
          cmd.step = 1'b1;
        end else if (sts.hold_valid) begin
          if (sts.out_free) begin
            cmd.flush  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/aer_datapath.sv -----
// ----------------------------------------------------------------------------
// aer_datapath
// Interval registers, shared multiplier, pending count, result hold and output.
// ----------------------------------------------------------------------------
module aer_datapath #(
  parameter int unsigned FREQ_BITS     = aer_pkg::FREQ_BITS_DEF,
  parameter int unsigned PENDING_WIDTH = aer_pkg::PENDING_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [aer_pkg::S_TDATA_W-1:0]  s_tdata,
  input  aer_pkg::aer_cmd_t              cmd,
  output aer_pkg::aer_sts_t              sts,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [aer_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tlast
);
  import aer_pkg::*;

  localparam int unsigned SPAN_W = RANGE_W + 1;
  localparam int unsigned PROD_W = SPAN_W + FREQ_BITS + 1;
  localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;
  localparam logic [FREQ_BITS:0]       FULL     = {1'b1, {FREQ_BITS{1'b0}}};

  // input decode
  logic [CUM_LOW_W-1:0]  in_clo;
  logic [CUM_HIGH_W-1:0] in_chi;
  logic [CUM_HIGH_W-1:0] full_ext;
  logic [CUM_HIGH_W-1:0] chi_clamp;

  // coder state
  logic [RANGE_W-1:0]       range_low;
  logic [RANGE_W-1:0]       range_high;
  logic [PENDING_WIDTH-1:0] pending_count;
  logic [PAD_W-1:0]         bit_phase;
  logic                     saturated_flag;

  // multiply operands and products
  logic [SPAN_W-1:0]    span;
  logic [FREQ_BITS-1:0] clo_q;
  logic [FREQ_BITS:0]   chi_q;
  logic [PROD_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_res;
  logic [PROD_W-1:0]    prod_hi;
  logic [PROD_W-1:0]    prod_lo;

  // held result and output register
  logic             hold_valid;
  logic             hold_bit;
  logic [RUN_W-1:0] hold_run;
  logic             hold_sat;
  logic             out_valid;
  logic             out_bit;
  logic [RUN_W-1:0] out_run;
  logic             out_sat;
  logic [PAD_W-1:0] out_pad;
  logic             out_last;

  logic                       e1, e2, e3, emit, out_free, push_hold;
  logic [PENDING_WIDTH+RUN_W-1:0] pend_ext;
  logic [RUN_W-1:0]           pend_run;
  logic                       pend_full;
  logic [PAD_W-1:0]           phase_emit;
  logic [PENDING_WIDTH-1:0]   fin_pend;
  logic [PENDING_WIDTH+RUN_W-1:0] fin_ext;
  logic [RUN_W-1:0]           fin_run;
  logic                       fin_sat;
  logic                       fin_bit;
  logic [PAD_W-1:0]           fin_phase;
  logic [PAD_W-1:0]           fin_pad;
  logic [RANGE_W-1:0]         high_upd;
  logic [RANGE_W-1:0]         low_upd;

  assign in_clo    = s_tdata[CUM_LOW_W-1:0];
  assign in_chi    = s_tdata[CUM_LOW_W +: CUM_HIGH_W];
  assign full_ext  = CUM_HIGH_W'(FULL);
  assign chi_clamp = (in_chi > full_ext) ? full_ext : in_chi;

  assign e1   = ~range_high[RANGE_W-1];
  assign e2   = range_low[RANGE_W-1];
  assign e3   = (range_low[RANGE_W-1 -: 2] == 2'b01) && (range_high[RANGE_W-1 -: 2] == 2'b10);
  assign emit = e1 | e2;

  assign out_free  = ~out_valid | m_tready;
  assign push_hold = (cmd.step & emit & hold_valid) | cmd.flush;

  assign sts.enc_ok     = {1'b0, in_clo} < chi_clamp;
  assign sts.emit       = emit;
  assign sts.e3         = e3;
  assign sts.hold_valid = hold_valid;
  assign sts.out_free   = out_free;

  // run lengths are reported modulo 2^32
  assign pend_ext   = {{RUN_W{1'b0}}, pending_count};
  assign pend_run   = pend_ext[RUN_W-1:0];
  assign pend_full  = (pending_count == PEND_MAX);
  assign phase_emit = bit_phase + PAD_W'(1) + pend_run[PAD_W-1:0];

  assign fin_pend  = pend_full ? PEND_MAX : pending_count + PENDING_WIDTH'(1);
  assign fin_ext   = {{RUN_W{1'b0}}, fin_pend};
  assign fin_run   = fin_ext[RUN_W-1:0];
  assign fin_sat   = saturated_flag | pend_full;
  assign fin_bit   = (range_low[RANGE_W-1 -: 2] != 2'b00);
  assign fin_phase = bit_phase + PAD_W'(1) + fin_run[PAD_W-1:0];
  assign fin_pad   = PAD_W'(0) - fin_phase;

  // one multiplier, high bound first
  assign mul_a   = PROD_W'(span);
  assign mul_b   = cmd.mul_hi ? PROD_W'(chi_q) : PROD_W'(clo_q);
  assign mul_res = mul_a * mul_b;

  assign high_upd = range_low - RANGE_W'(1) + prod_hi[FREQ_BITS +: RANGE_W];
  assign low_upd  = range_low + prod_lo[FREQ_BITS +: RANGE_W];

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(M_TDATA_W - RUN_W - PAD_W - 2){1'b0}},
                     out_pad, out_sat, out_run, out_bit};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low      <= '0;
      range_high     <= '1;
      pending_count  <= '0;
      bit_phase      <= '0;
      saturated_flag <= 1'b0;
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.finish) begin
        range_low      <= '0;
        range_high     <= '1;
        pending_count  <= '0;
        bit_phase      <= '0;
        saturated_flag <= 1'b0;
      end else if (cmd.update) begin
        range_low  <= low_upd;
        range_high <= high_upd;
      end else if (cmd.step) begin
        if (emit) begin
          pending_count  <= '0;
          saturated_flag <= 1'b0;
          bit_phase      <= phase_emit;
          range_low      <= {range_low[RANGE_W-2:0], 1'b0};
          range_high     <= {range_high[RANGE_W-2:0], 1'b1};
        end else begin
          if (pend_full) begin
            saturated_flag <= 1'b1;
          end else begin
            pending_count <= pending_count + PENDING_WIDTH'(1);
          end
          range_low  <= {1'b0, range_low[RANGE_W-3:0], 1'b0};
          range_high <= {1'b1, range_high[RANGE_W-3:0], 1'b1};
        end
      end

      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end else if (cmd.step && emit) begin
        hold_valid <= 1'b1;
      end

      if (push_hold || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span  <= {1'b0, range_high} - {1'b0, range_low} + SPAN_W'(1);
      clo_q <= in_clo[FREQ_BITS-1:0];
      chi_q <= chi_clamp[FREQ_BITS:0];
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_res;
    end
    if (cmd.mul_lo) begin
      prod_lo <= mul_res;
    end
    if (cmd.step && emit) begin
      hold_bit <= e2;
      hold_run <= pend_run;
      hold_sat <= saturated_flag;
    end
    if (push_hold) begin
      out_bit  <= hold_bit;
      out_run  <= hold_run;
      out_sat  <= hold_sat;
      out_pad  <= '0;
      out_last <= cmd.flush;
    end else if (cmd.finish) begin
      out_bit  <= fin_bit;
      out_run  <= fin_run;
      out_sat  <= fin_sat;
      out_pad  <= fin_pad;
      out_last <= 1'b1;
    end
  end

endmodule
